[hdl/ppt_pkg.sv]
// ppt_pkg: shared widths, reset values, register indexes and state type
// for the pulse period tachometer. No dependencies.
`timescale 1ns / 1ps

package ppt_pkg;

  // default values of the top level parameters
  localparam int TIME_WIDTH_DEF       = 32;
  localparam int EDGE_COUNT_WIDTH_DEF = 8;

  // fixed field widths
  localparam int PPE_W   = 8;
  localparam int PPR_W   = 8;
  localparam int IVL_W   = 32;
  localparam int TPM_W   = 26;
  localparam int SPEED_W = 34;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 34;

  // one count register serves the multiply and the divide passes
  localparam int CNT_W = $clog2(SPEED_W);

  // register reset values
  localparam logic [PPE_W-1:0]   PPE_RST   = PPE_W'(1);
  localparam logic [PPR_W-1:0]   PPR_RST   = PPR_W'(1);
  localparam logic [IVL_W-1:0]   IMIN_RST  = IVL_W'(1);
  localparam logic [IVL_W-1:0]   IMAX_RST  = '1;
  localparam logic [TPM_W-1:0]   TPM_RST   = TPM_W'(60000000);
  localparam logic [SPEED_W-1:0] FLOOR_RST = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PULSES_PER_EVENT = 3'd0,
    REG_PULSES_PER_REV   = 3'd1,
    REG_INTERVAL_MIN     = 3'd2,
    REG_INTERVAL_MAX     = 3'd3,
    REG_TICKS_PER_MINUTE = 3'd4,
    REG_SPEED_FLOOR      = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_LOAD
  } ppt_state_t;

endpackage

[hdl/ppt_if.sv]
// ppt_if: valid/ready channel interfaces for the tick input, the speed
// result and the register write port. Depends on ppt_pkg.
`timescale 1ns / 1ps

interface ppt_in_if;
  logic valid;
  logic ready;
  logic edge_seen;
  logic read_request;

  modport source (output valid, output edge_seen, output read_request, input ready);
  modport sink (input valid, input edge_seen, input read_request, output ready);
endinterface

interface ppt_out_if;
  logic                        valid;
  logic                        ready;
  logic [ppt_pkg::SPEED_W-1:0] speed_rpm;
  logic                        speed_is_new;

  modport source (output valid, output speed_rpm, output speed_is_new, input ready);
  modport sink (input valid, input speed_rpm, input speed_is_new, output ready);
endinterface

interface ppt_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ppt_pkg::CFG_IDX_W-1:0]  index;
  logic [ppt_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/pulse_period_tachometer.sv]
// Pulse period tachometer: each input item is one timebase tick; an item that
// carries no read request is taken and the block is ready again in the next
// cycle. An item with a read request occupies the block until its result sits
// in the output register: first the tick update, then the bit-serial shift-add
// products (pulses_per_event x ticks_per_minute and interval x pulses_per_rev),
// then the restoring divider that retires one quotient bit per cycle, and
// last the load of the output register. A stalled output adds the cycles
// spent waiting for the previous result to be taken. Zero divisors read as
// all ones before the floor test. Register writes are taken at any time, but
// belong to idle periods.
// Depends on ppt_pkg and ppt_if.
`timescale 1ns / 1ps

module pulse_period_tachometer #(
  parameter int TIME_WIDTH       = ppt_pkg::TIME_WIDTH_DEF,
  parameter int EDGE_COUNT_WIDTH = ppt_pkg::EDGE_COUNT_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ppt_in_if.sink    in_if,
  ppt_out_if.source out_if,
  ppt_cfg_if.sink   cfg_if
);

  localparam int SPEED_W = ppt_pkg::SPEED_W;
  localparam int PPE_W   = ppt_pkg::PPE_W;
  localparam int PPR_W   = ppt_pkg::PPR_W;
  localparam int IVL_W   = ppt_pkg::IVL_W;
  localparam int TPM_W   = ppt_pkg::TPM_W;
  localparam int CNT_W   = ppt_pkg::CNT_W;
  localparam int DEN_W   = TIME_WIDTH + PPR_W;
  localparam int ECMP_W  = (EDGE_COUNT_WIDTH > PPE_W) ? EDGE_COUNT_WIDTH : PPE_W;
  localparam int CLW     = (TIME_WIDTH > IVL_W) ? TIME_WIDTH : IVL_W;

  // configuration registers
  logic [PPE_W-1:0]   ppe_r;
  logic [PPR_W-1:0]   ppr_r;
  logic [IVL_W-1:0]   imin_r;
  logic [IVL_W-1:0]   imax_r;
  logic [TPM_W-1:0]   tpm_r;
  logic [SPEED_W-1:0] floor_r;

  // tick state
  logic [EDGE_COUNT_WIDTH-1:0] edge_cnt_r, edge_cnt_nxt;
  logic [TIME_WIDTH-1:0]       elapsed_r, elapsed_nxt;
  logic [TIME_WIDTH-1:0]       interval_r, interval_nxt;
  logic                        new_flag_r, new_flag_nxt;

  // sequencer and serial datapath
  ppt_pkg::ppt_state_t state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SPEED_W-1:0]  num_r, num_nxt;
  logic [SPEED_W-1:0]  tpm_sh_r, tpm_sh_nxt;
  logic [PPE_W-1:0]    ppe_sh_r, ppe_sh_nxt;
  logic [DEN_W-1:0]    den_r, den_nxt;
  logic [DEN_W-1:0]    ivl_sh_r, ivl_sh_nxt;
  logic [PPR_W-1:0]    ppr_sh_r, ppr_sh_nxt;
  logic [DEN_W-1:0]    rem_r, rem_nxt;
  logic                pend_new_r, pend_new_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [SPEED_W-1:0] out_speed_r, out_speed_nxt;
  logic               out_new_r, out_new_nxt;

  // tick update terms
  logic [TIME_WIDTH-1:0]       elapsed_inc;
  logic [EDGE_COUNT_WIDTH-1:0] edge_inc;
  logic                        hit;
  logic [CLW-1:0]              clamp_v;
  logic [TIME_WIDTH-1:0]       ivl_clamped;
  logic [DEN_W:0]              trial;
  logic                        trial_ge;
  logic                        in_acc;
  logic                        out_free;

  assign in_if.ready  = (state_r == ppt_pkg::ST_IDLE);
  assign cfg_if.ready = 1'b1;
  assign in_acc       = in_if.valid && in_if.ready;
  assign out_free     = !out_valid_r || out_if.ready;

  assign out_if.valid        = out_valid_r;
  assign out_if.speed_rpm    = out_speed_r;
  assign out_if.speed_is_new = out_new_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppe_r   <= ppt_pkg::PPE_RST;
      ppr_r   <= ppt_pkg::PPR_RST;
      imin_r  <= ppt_pkg::IMIN_RST;
      imax_r  <= ppt_pkg::IMAX_RST;
      tpm_r   <= ppt_pkg::TPM_RST;
      floor_r <= ppt_pkg::FLOOR_RST;
    end else if (cfg_if.valid && cfg_if.ready) begin
      unique case (ppt_pkg::cfg_reg_t'(cfg_if.index))
        ppt_pkg::REG_PULSES_PER_EVENT: ppe_r   <= cfg_if.data[PPE_W-1:0];
        ppt_pkg::REG_PULSES_PER_REV:   ppr_r   <= cfg_if.data[PPR_W-1:0];
        ppt_pkg::REG_INTERVAL_MIN:     imin_r  <= cfg_if.data[IVL_W-1:0];
        ppt_pkg::REG_INTERVAL_MAX:     imax_r  <= cfg_if.data[IVL_W-1:0];
        ppt_pkg::REG_TICKS_PER_MINUTE: tpm_r   <= cfg_if.data[TPM_W-1:0];
        ppt_pkg::REG_SPEED_FLOOR:      floor_r <= cfg_if.data[SPEED_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // saturating counters, capture test and interval clamp
  always_comb begin
    elapsed_inc = (&elapsed_r) ? elapsed_r : elapsed_r + 1'b1;
    edge_inc    = (&edge_cnt_r) ? edge_cnt_r : edge_cnt_r + 1'b1;
    hit         = in_if.edge_seen && (ECMP_W'(edge_inc) >= ECMP_W'(ppe_r));
    clamp_v     = CLW'(elapsed_inc);
    if (clamp_v <= CLW'(imin_r)) begin
      clamp_v = CLW'(imin_r);
    end else if (clamp_v > CLW'(imax_r)) begin
      clamp_v = CLW'(imax_r);
    end
    if ((clamp_v >> TIME_WIDTH) != '0) begin
      ivl_clamped = '1;
    end else begin
      ivl_clamped = clamp_v[TIME_WIDTH-1:0];
    end
  end

  // one restoring divide step; a zero divisor yields all ones by itself
  assign trial    = {rem_r, num_r[SPEED_W-1]};
  assign trial_ge = trial >= {1'b0, den_r};

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    edge_cnt_nxt  = edge_cnt_r;
    elapsed_nxt   = elapsed_r;
    interval_nxt  = interval_r;
    new_flag_nxt  = new_flag_r;
    num_nxt       = num_r;
    tpm_sh_nxt    = tpm_sh_r;
    ppe_sh_nxt    = ppe_sh_r;
    den_nxt       = den_r;
    ivl_sh_nxt    = ivl_sh_r;
    ppr_sh_nxt    = ppr_sh_r;
    rem_nxt       = rem_r;
    pend_new_nxt  = pend_new_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_speed_nxt = out_speed_r;
    out_new_nxt   = out_new_r;

    unique case (state_r)
      ppt_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (hit) begin
            edge_cnt_nxt = '0;
            elapsed_nxt  = '0;
            interval_nxt = ivl_clamped;
          end else begin
            edge_cnt_nxt = in_if.edge_seen ? edge_inc : edge_cnt_r;
            elapsed_nxt  = elapsed_inc;
          end
          new_flag_nxt = hit || new_flag_r;
          if (in_if.read_request) begin
            pend_new_nxt = hit || new_flag_r;
            new_flag_nxt = 1'b0;
            num_nxt      = '0;
            tpm_sh_nxt   = SPEED_W'(tpm_r);
            ppe_sh_nxt   = ppe_r;
            den_nxt      = '0;
            ivl_sh_nxt   = DEN_W'(hit ? ivl_clamped : interval_r);
            ppr_sh_nxt   = ppr_r;
            cnt_nxt      = CNT_W'(PPE_W - 1);
            state_nxt    = ppt_pkg::ST_MUL;
          end
        end
      end
      ppt_pkg::ST_MUL: begin
        // shift-add, one multiplier bit of each product per cycle
        if (ppe_sh_r[0]) begin
          num_nxt = num_r + tpm_sh_r;
        end
        if (ppr_sh_r[0]) begin
          den_nxt = den_r + ivl_sh_r;
        end
        tpm_sh_nxt = tpm_sh_r << 1;
        ivl_sh_nxt = ivl_sh_r << 1;
        ppe_sh_nxt = ppe_sh_r >> 1;
        ppr_sh_nxt = ppr_sh_r >> 1;
        if (cnt_r == '0) begin
          rem_nxt   = '0;
          cnt_nxt   = CNT_W'(SPEED_W - 1);
          state_nxt = ppt_pkg::ST_DIV;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ppt_pkg::ST_DIV: begin
        // numerator bits leave at the top of num_r, quotient bits enter below
        rem_nxt = trial_ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
        num_nxt = {num_r[SPEED_W-2:0], trial_ge};
        if (cnt_r == '0) begin
          state_nxt = ppt_pkg::ST_LOAD;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ppt_pkg::ST_LOAD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_speed_nxt = (num_r <= floor_r) ? '0 : num_r;
          out_new_nxt   = pend_new_r;
          state_nxt     = ppt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ppt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ppt_pkg::ST_IDLE;
      cnt_r       <= '0;
      edge_cnt_r  <= '0;
      elapsed_r   <= '0;
      interval_r  <= '1;
      new_flag_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      edge_cnt_r  <= edge_cnt_nxt;
      elapsed_r   <= elapsed_nxt;
      interval_r  <= interval_nxt;
      new_flag_r  <= new_flag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r       <= num_nxt;
    tpm_sh_r    <= tpm_sh_nxt;
    ppe_sh_r    <= ppe_sh_nxt;
    den_r       <= den_nxt;
    ivl_sh_r    <= ivl_sh_nxt;
    ppr_sh_r    <= ppr_sh_nxt;
    rem_r       <= rem_nxt;
    pend_new_r  <= pend_new_nxt;
    out_speed_r <= out_speed_nxt;
    out_new_r   <= out_new_nxt;
  end

endmodule

[hdl/ppt_checker.sv]
// ppt_checker: port-level checks for the pulse period tachometer, attached
// by the bind at the end of this file. Depends on ppt_pkg and the top level.
`timescale 1ns / 1ps

module ppt_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_read_request,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ppt_pkg::SPEED_W-1:0] out_speed_rpm,
  input logic                        out_speed_is_new
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_speed_rpm) && $stable(out_speed_is_new))
    else $error("result changed while stalled");

  // a read item starts the multiply and divide passes, so the next tick must wait
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_read_request |=> !in_ready)
    else $error("item accepted while a read is in progress");

  // a plain tick never blocks the following one
  a_tick_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_read_request |=> in_ready)
    else $error("plain tick left the block busy");

endmodule

bind pulse_period_tachometer ppt_checker u_ppt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_if.valid),
  .in_ready         (in_if.ready),
  .in_read_request  (in_if.read_request),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .out_speed_rpm    (out_if.speed_rpm),
  .out_speed_is_new (out_if.speed_is_new)
);

[sim/testbench.sv]
// testbench: self-checking bench for pulse_period_tachometer; predicts each speed
// read from its own tick model and compares it with the result channel.
// Depends on ppt_pkg, ppt_if and the pulse_period_tachometer rtl.
`timescale 1ns / 1ps

module testbench;

  localparam int PPE_W      = ppt_pkg::PPE_W;
  localparam int PPR_W      = ppt_pkg::PPR_W;
  localparam int IVL_W      = ppt_pkg::IVL_W;
  localparam int TPM_W      = ppt_pkg::TPM_W;
  localparam int SPEED_W    = ppt_pkg::SPEED_W;
  localparam int CFG_DATA_W = ppt_pkg::CFG_DATA_W;

  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [TPM_W-1:0]   TPM_TOP   = '1;
  localparam logic [SPEED_W-1:0] SPEED_TOP = '1;

  typedef struct packed {
    logic [SPEED_W-1:0] rpm;
    logic               is_new;
  } speed_result_t;

  logic clk;
  logic rst_n;

  ppt_in_if  in_ch ();
  ppt_out_if res_ch ();
  ppt_cfg_if cfg_ch ();

  pulse_period_tachometer u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (res_ch),
    .cfg_if (cfg_ch)
  );

  // register copies
  logic [PPE_W-1:0]   ppe_q;
  logic [PPR_W-1:0]   ppr_q;
  logic [IVL_W-1:0]   imin_q;
  logic [IVL_W-1:0]   imax_q;
  logic [TPM_W-1:0]   tpm_q;
  logic [SPEED_W-1:0] floor_q;

  // tick model state
  logic [7:0]         edge_cnt;
  logic [IVL_W-1:0]   elapsed;
  logic [IVL_W-1:0]   interval;
  logic               fresh;

  speed_result_t expected_speeds[$];

  int tick_gap_pct = 22;
  int stall_pct    = 56;
  int err_count    = 0;
  int cycle_count  = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void model_reset();
    ppe_q    = ppt_pkg::PPE_RST;
    ppr_q    = ppt_pkg::PPR_RST;
    imin_q   = ppt_pkg::IMIN_RST;
    imax_q   = ppt_pkg::IMAX_RST;
    tpm_q    = ppt_pkg::TPM_RST;
    floor_q  = ppt_pkg::FLOOR_RST;
    edge_cnt = '0;
    elapsed  = '0;
    interval = '1;
    fresh    = 1'b0;
  endfunction

  function automatic logic [SPEED_W-1:0] predicted_rpm();
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quo;
    num = 64'(ppe_q) * 64'(tpm_q);
    den = 64'(interval) * 64'(ppr_q);
    quo = (den == 0) ? 64'(SPEED_TOP) : num / den;
    if (quo[SPEED_W-1:0] <= floor_q) return '0;
    return quo[SPEED_W-1:0];
  endfunction

  function automatic void tick_model(input logic edge_in, input logic read_in);
    speed_result_t res;
    if (elapsed != '1) elapsed++;
    if (edge_in) begin
      if (edge_cnt != '1) edge_cnt++;
      // zero pulses per event falls through here on every edge
      if (edge_cnt >= ppe_q) begin
        if (elapsed <= imin_q) begin
          interval = imin_q;
        end else if (elapsed > imax_q) begin
          interval = imax_q;
        end else begin
          interval = elapsed;
        end
        elapsed  = '0;
        edge_cnt = '0;
        fresh    = 1'b1;
      end
    end
    if (read_in) begin
      res.rpm    = predicted_rpm();
      res.is_new = fresh;
      expected_speeds.push_back(res);
      fresh = 1'b0;
    end
  endfunction

  always @(posedge clk) begin : check_speed
    speed_result_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (expected_speeds.size() == 0) begin
        $error("speed result with none pending: speed_rpm %0d speed_is_new %0d",
               res_ch.speed_rpm, res_ch.speed_is_new);
        err_count++;
      end else begin
        want = expected_speeds.pop_front();
        if (res_ch.speed_rpm !== want.rpm) begin
          $error("speed_rpm: expected %0d, got %0d", want.rpm, res_ch.speed_rpm);
          err_count++;
        end
        if (res_ch.speed_is_new !== want.is_new) begin
          $error("speed_is_new: expected %0d, got %0d", want.is_new, res_ch.speed_is_new);
          err_count++;
        end
      end
    end
    res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // valid stays high after an accepted item so back-to-back items need no drop
  task automatic send_tick(input logic edge_in, input logic read_in);
    while ($urandom_range(0, 99) < tick_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.edge_seen    <= edge_in;
    in_ch.read_request <= read_in;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tick_model(edge_in, read_in);
  endtask

  task automatic wait_for_speeds();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_speeds.size() != 0) @(posedge clk);
  endtask

  task automatic write_settings(input logic [PPE_W-1:0] ppe, input logic [PPR_W-1:0] ppr,
                                input logic [IVL_W-1:0] lo, input logic [IVL_W-1:0] hi,
                                input logic [TPM_W-1:0] tpm, input logic [SPEED_W-1:0] flr);
    logic [CFG_DATA_W-1:0] vals [6];
    ppt_pkg::cfg_reg_t idx;
    int i;
    wait_for_speeds();
    // a tick without a read may still be in flight
    repeat (50) @(posedge clk);
    vals[0] = CFG_DATA_W'(ppe);
    vals[1] = CFG_DATA_W'(ppr);
    vals[2] = CFG_DATA_W'(lo);
    vals[3] = CFG_DATA_W'(hi);
    vals[4] = CFG_DATA_W'(tpm);
    vals[5] = CFG_DATA_W'(flr);
    for (i = 0; i < 6; i++) begin
      idx = ppt_pkg::cfg_reg_t'(i);
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx;
      cfg_ch.data  <= vals[i];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      case (idx)
        ppt_pkg::REG_PULSES_PER_EVENT: ppe_q   = vals[i][PPE_W-1:0];
        ppt_pkg::REG_PULSES_PER_REV:   ppr_q   = vals[i][PPR_W-1:0];
        ppt_pkg::REG_INTERVAL_MIN:     imin_q  = vals[i][IVL_W-1:0];
        ppt_pkg::REG_INTERVAL_MAX:     imax_q  = vals[i][IVL_W-1:0];
        ppt_pkg::REG_TICKS_PER_MINUTE: tpm_q   = vals[i][TPM_W-1:0];
        ppt_pkg::REG_SPEED_FLOOR:      floor_q = vals[i][SPEED_W-1:0];
        default: ;
      endcase
    end
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // steady rotation: an edge every period ticks with jitter, plus stray edge noise
  task automatic spin(input int n_ticks, input int period, input int read_pct,
                      input int noise_pct);
    int since;
    int k;
    logic e;
    logic rd;
    since = 0;
    for (k = 0; k < n_ticks; k++) begin
      since++;
      e = (since >= period);
      if (e) since = $urandom_range(0, period / 4);
      if ($urandom_range(0, 99) < noise_pct) e = ~e;
      rd = ($urandom_range(0, 99) < read_pct);
      send_tick(e, rd);
      if ($urandom_range(0, 199) == 0) wait_for_speeds();
    end
  endtask

  task automatic test_directed_cases();
    // reset settings: read before any capture, then captures and re-reads
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    // zero pulses per event and zero pulses per rev
    write_settings('0, '0, '0, '1, TPM_TOP, '0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    // min above max: short interval takes min, long one takes max
    write_settings(8'd1, 8'd1, 32'd3, 32'd2, 26'd1000, '0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    // max of zero gives a zero interval
    write_settings(8'd1, 8'd1, 32'd1, '0, 26'd1000, '0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    // speed equal to the floor reads zero, one above reads through
    write_settings(8'd1, 8'd1, 32'd1, '1, TPM_TOP, SPEED_W'(TPM_TOP));
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    write_settings(8'd1, 8'd1, 32'd1, '1, TPM_TOP, SPEED_W'(TPM_TOP) - 1);
    send_tick(1'b0, 1'b1);
    write_settings(8'd255, 8'd1, 32'd1, '1, TPM_TOP, SPEED_TOP);
    send_tick(1'b1, 1'b1);
  endtask

  task automatic test_edge_count_limit();
    // largest edge count per capture; max clamp of 1 keeps speed at ppe x tpm
    write_settings(8'd255, 8'd1, 32'd1, 32'd1, TPM_TOP, '0);
    spin(260, 1, 8, 0);
  endtask

  task automatic test_random_traffic();
    int p;
    int ph;
    int period;
    logic [PPE_W-1:0]   ppe;
    logic [PPR_W-1:0]   ppr;
    logic [IVL_W-1:0]   lo;
    logic [IVL_W-1:0]   hi;
    logic [TPM_W-1:0]   tpm;
    logic [SPEED_W-1:0] flr;
    for (p = 0; p < 3; p++) begin
      case (p)
        0: begin
          tick_gap_pct = 22;
          stall_pct    = 56;
        end
        1: begin
          tick_gap_pct = 56;
          stall_pct    = 22;
        end
        default: begin
          tick_gap_pct = 0;
          stall_pct    = 0;
        end
      endcase
      for (ph = 0; ph < 3; ph++) begin
        ppe = ($urandom_range(0, 5) == 0) ? PPE_W'($urandom_range(0, 255))
                                          : PPE_W'($urandom_range(1, 4));
        ppr = ($urandom_range(0, 7) == 0) ? PPR_W'($urandom) : PPR_W'($urandom_range(1, 8));
        lo  = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(1, 6);
        case ($urandom_range(0, 3))
          0:       hi = $urandom_range(1, 20);
          1:       hi = $urandom;
          default: hi = '1;
        endcase
        tpm = TPM_W'($urandom);
        case ($urandom_range(0, 3))
          0, 1:    flr = '0;
          2:       flr = SPEED_W'($urandom_range(0, 2000000));
          default: flr = SPEED_W'({$urandom, $urandom});
        endcase
        period = $urandom_range(1, 10);
        write_settings(ppe, ppr, lo, hi, tpm, flr);
        spin(16, period, 30, 8);
        // hold off new ticks until every pending speed is out
        if (ph == 1) wait_for_speeds();
        spin(16, period, 30, 8);
      end
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.edge_seen    = 1'b0;
    in_ch.read_request = 1'b0;
    res_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = ppt_pkg::REG_PULSES_PER_EVENT;
    cfg_ch.data        = '0;
    model_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_edge_count_limit();
    test_random_traffic();
    wait_for_speeds();
    repeat (60) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/ppt_pkg.sv
hdl/ppt_if.sv
hdl/pulse_period_tachometer.sv
hdl/ppt_checker.sv
sim/testbench.sv
